### rtl/sip13_pkg.sv
package sip13_pkg;

    // initial lanes under an all-zero key
    localparam logic [63:0] LANE0_INIT = 64'h736f6d6570736575;
    localparam logic [63:0] LANE1_INIT = 64'h646f72616e646f6d;
    localparam logic [63:0] LANE2_INIT = 64'h6c7967656e657261;
    localparam logic [63:0] LANE3_INIT = 64'h7465646279746573;

    localparam logic [63:0] FINAL_XOR     = 64'h00000000000000ff;
    localparam logic [63:0] HASH_ALL_ONES = 64'hffffffffffffffff;
    localparam logic [63:0] HASH_REPLACE  = 64'hfffffffffffffffe;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // work handed from the front to the back
    typedef enum logic [1:0] {
        OP_COMPRESS,
        OP_FINAL,
        OP_BOTH,
        OP_EMPTY
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [63:0] word;
        logic [7:0]  total;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic full;
    } t_fifo_stat;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } t_lanes;

endpackage

### rtl/sip13_if.sv
interface sip13_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       is_last;

    modport source (output valid, output data_byte, output byte_valid, output is_last,
                    input ready);
    modport sink (input valid, input data_byte, input byte_valid, input is_last,
                  output ready);
endinterface

interface sip13_hash_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink (input valid, input hash_value, output ready);
endinterface

### rtl/sip13_front.sv
module sip13_front
    import sip13_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    sip13_req_if.sink    i_req,
    input  t_fifo_stat   i_stat,
    output logic         o_push,
    output t_cmd         o_cmd
);

    logic [63:0] r_pend;
    logic [7:0]  r_total;
    logic        r_open;

    logic [63:0] n_pend;
    logic [7:0]  n_total;
    logic        n_open;

    logic        w_accept;
    logic        w_full_word;
    logic [63:0] w_packed;
    logic [7:0]  w_total_inc;

    assign i_req.ready = !i_stat.full;
    assign w_accept    = i_req.valid && i_req.ready;

    always_comb begin
        w_packed    = r_pend | ({56'd0, i_req.data_byte} << {r_total[2:0], 3'b000});
        w_total_inc = r_total + 8'd1;
        w_full_word = (r_total[2:0] == 3'b111);

        o_cmd.op    = OP_FINAL;
        o_cmd.word  = i_req.byte_valid ? w_packed : r_pend;
        o_cmd.total = i_req.byte_valid ? w_total_inc : r_total;
        if (i_req.byte_valid && w_full_word) begin
            o_cmd.op = i_req.is_last ? OP_BOTH : OP_COMPRESS;
        end else if (i_req.is_last && !r_open && !i_req.byte_valid) begin
            o_cmd.op = OP_EMPTY;
        end
        o_push = w_accept && (i_req.is_last || (i_req.byte_valid && w_full_word));

        n_pend  = r_pend;
        n_total = r_total;
        n_open  = r_open;
        if (w_accept) begin
            if (i_req.is_last) begin
                n_pend  = '0;
                n_total = '0;
                n_open  = 1'b0;
            end else if (i_req.byte_valid) begin
                n_pend  = w_full_word ? 64'd0 : w_packed;
                n_total = w_total_inc;
                n_open  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_total <= '0;
            r_open  <= 1'b0;
        end else begin
            r_pend  <= n_pend;
            r_total <= n_total;
            r_open  <= n_open;
        end
    end

endmodule

### rtl/sip13_fifo.sv
module sip13_fifo
    import sip13_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_cmd        i_cmd,
    input  logic        i_pop,
    output t_cmd        o_cmd,
    output t_fifo_stat  o_stat
);

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    assign o_cmd        = r_mem[r_rd_ptr];
    assign o_stat.valid = (r_count != '0);
    assign o_stat.full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (FIFO_AW+1)'(1);
                2'b01:   r_count <= r_count - (FIFO_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/sip13_back.sv
module sip13_back
    import sip13_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  t_fifo_stat    i_stat,
    output logic          o_pop,
    sip13_hash_if.source  o_hash
);

    localparam logic [2:0] STEP_FIRST = 3'd0;
    localparam logic [2:0] STEP_MIX   = 3'd1;
    localparam logic [2:0] STEP_LAST  = 3'd7;

    // first half of a round: one add deep
    function automatic t_lanes half_a(input t_lanes l);
        t_lanes      r;
        logic [63:0] s0;
        logic [63:0] s2;
        s0   = l.v0 + l.v1;
        s2   = l.v2 + l.v3;
        r.v1 = {l.v1[50:0], l.v1[63:51]} ^ s0;
        r.v0 = {s0[31:0], s0[63:32]};
        r.v3 = {l.v3[47:0], l.v3[63:48]} ^ s2;
        r.v2 = s2;
        return r;
    endfunction

    // second half of a round
    function automatic t_lanes half_b(input t_lanes l);
        t_lanes      r;
        logic [63:0] s0;
        logic [63:0] s2;
        s0   = l.v0 + l.v3;
        s2   = l.v2 + l.v1;
        r.v3 = {l.v3[42:0], l.v3[63:43]} ^ s0;
        r.v0 = s0;
        r.v1 = {l.v1[46:0], l.v1[63:47]} ^ s2;
        r.v2 = {s2[31:0], s2[63:32]};
        return r;
    endfunction

    t_lanes      r_lanes;
    logic        r_busy;
    logic [2:0]  r_step;
    logic [63:0] r_word;
    logic [7:0]  r_tail;
    logic        r_pre;
    logic        r_final;
    logic        r_out_valid;
    logic [63:0] r_out_hash;

    t_lanes      n_lanes;
    logic        n_busy;
    logic [2:0]  n_step;
    logic [63:0] n_word;
    logic [7:0]  n_tail;
    logic        n_pre;
    logic        n_final;
    logic        n_out_valid;
    logic [63:0] n_out_hash;

    t_lanes      w_in;
    t_lanes      w_calc;
    logic [63:0] w_hash;
    logic        w_out_free;
    logic        w_advance;
    logic        w_finish;
    logic        w_is_empty;

    assign o_hash.valid      = r_out_valid;
    assign o_hash.hash_value = r_out_hash;

    always_comb begin
        w_out_free = !r_out_valid || o_hash.ready;
        w_in       = r_lanes;

        if (r_step[0] == 1'b0) begin
            if (r_step == STEP_FIRST) begin
                w_in.v3 = r_lanes.v3 ^ r_word;
            end
            w_calc = half_a(w_in);
        end else begin
            w_calc = half_b(w_in);
            if (r_step == STEP_MIX) begin
                w_calc.v0 = w_calc.v0 ^ r_word;
                if (!r_pre && r_final) begin
                    w_calc.v2 = w_calc.v2 ^ FINAL_XOR;
                end
            end
        end

        w_hash = w_calc.v0 ^ w_calc.v1 ^ w_calc.v2 ^ w_calc.v3;
        if (w_hash == HASH_ALL_ONES) begin
            w_hash = HASH_REPLACE;
        end

        w_advance  = r_busy && !(r_step == STEP_LAST && !w_out_free);
        w_finish   = w_advance && (r_step == STEP_LAST ||
                     (r_step == STEP_MIX && !r_pre && !r_final));
        w_is_empty = (i_cmd.op == OP_EMPTY);
        o_pop      = i_stat.valid && (w_is_empty ? (!r_busy && w_out_free)
                                                 : (!r_busy || w_finish));

        n_lanes     = r_lanes;
        n_busy      = r_busy;
        n_step      = r_step;
        n_word      = r_word;
        n_tail      = r_tail;
        n_pre       = r_pre;
        n_final     = r_final;
        n_out_valid = r_out_valid && !o_hash.ready;
        n_out_hash  = r_out_hash;

        if (w_advance) begin
            if (r_step == STEP_LAST) begin
                // message done: lanes back to their start values
                n_lanes.v0  = LANE0_INIT;
                n_lanes.v1  = LANE1_INIT;
                n_lanes.v2  = LANE2_INIT;
                n_lanes.v3  = LANE3_INIT;
                n_out_valid = 1'b1;
                n_out_hash  = w_hash;
            end else begin
                n_lanes = w_calc;
            end
            if (r_step == STEP_MIX && r_pre) begin
                // full word done, now the length-only tail word
                n_pre  = 1'b0;
                n_step = STEP_FIRST;
                n_word = {r_tail, 56'd0};
            end else if (w_finish) begin
                n_busy = 1'b0;
            end else begin
                n_step = r_step + 3'd1;
            end
        end

        if (o_pop) begin
            if (w_is_empty) begin
                n_out_valid = 1'b1;
                n_out_hash  = '0;
            end else begin
                n_busy  = 1'b1;
                n_step  = STEP_FIRST;
                n_tail  = i_cmd.total;
                n_pre   = (i_cmd.op == OP_BOTH);
                n_final = (i_cmd.op != OP_COMPRESS);
                n_word  = (i_cmd.op == OP_FINAL) ? (i_cmd.word | {i_cmd.total, 56'd0})
                                                 : i_cmd.word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word     <= n_word;
        r_tail     <= n_tail;
        r_out_hash <= n_out_hash;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lanes.v0  <= LANE0_INIT;
            r_lanes.v1  <= LANE1_INIT;
            r_lanes.v2  <= LANE2_INIT;
            r_lanes.v3  <= LANE3_INIT;
            r_busy      <= 1'b0;
            r_step      <= STEP_FIRST;
            r_pre       <= 1'b0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_lanes     <= n_lanes;
            r_busy      <= n_busy;
            r_step      <= n_step;
            r_pre       <= n_pre;
            r_final     <= n_final;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/siphash13_string_hash.sv
// throughput: one byte request per cycle while the queue is not full
// from an idle back end the last request passes the queue, a word compression if its byte
//   closes a word, tail compression and three finalization rounds; an empty message skips them
// each round is split into two half rounds, the last half round loads the output register directly
// reset: synchronous active low; lanes load the key-zero start values, queue empties,
//   no clearing pass, requests accepted right after reset
module siphash13_string_hash
    import sip13_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    sip13_req_if.sink    i_req,
    sip13_hash_if.source o_hash
);

    // front -> queue
    logic       w_push;
    t_cmd       w_push_cmd;

    // queue -> back
    logic       w_pop;
    t_cmd       w_head_cmd;
    t_fifo_stat w_stat;

    // front packs bytes little-endian and emits one command per full word
    // or per message end; a word that closes on the last byte merges both
    sip13_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_stat  (w_stat),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    // short queue soaks up finalization while bytes of the next message stream in
    sip13_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_stat  (w_stat)
    );

    // back runs half rounds on the four lanes and holds the result register
    sip13_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_head_cmd),
        .i_stat  (w_stat),
        .o_pop   (w_pop),
        .o_hash  (o_hash)
    );

endmodule
